// ===== rtl/core/pan_tilt_target_search_sequencer_top_assert.svh =====
// ----------------------------------------------------------------------------
// Pan/tilt search sequencer assertion macros
// Shared wrappers for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PAN_TILT_TARGET_SEARCH_SEQUENCER_TOP_ASSERT_SVH
`define PAN_TILT_TARGET_SEARCH_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, skipped while reset is high
`define PTTS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, skipped while reset is high
`define PTTS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/ptts_pkg.sv =====
// ----------------------------------------------------------------------------
// Pan/tilt search sequencer package
// Codes, configuration record and control record shared by the core modules.
// ----------------------------------------------------------------------------
package ptts_pkg;

   // Field widths
   localparam int FovWidth    = 16;
   localparam int PanBndWidth = 17;
   localparam int TiltWidth   = 16;
   localparam int OffsetWidth = 16;
   localparam int AngleWidth  = 18;
   localparam int KindWidth   = 2;
   localparam int SelWidth    = 3;
   localparam int PhaseWidth  = 2;
   localparam int CsrIdxWidth = 3;
   localparam int CsrDatWidth = 17;

   // Command kinds
   localparam logic [KindWidth-1:0] KIND_NONE = 2'd0;
   localparam logic [KindWidth-1:0] KIND_REL  = 2'd1;
   localparam logic [KindWidth-1:0] KIND_ABS  = 2'd2;

   // Angle source selects
   localparam logic [SelWidth-1:0] SEL_ZERO = 3'd0;
   localparam logic [SelWidth-1:0] SEL_REL  = 3'd1;
   localparam logic [SelWidth-1:0] SEL_ABS  = 3'd2;
   localparam logic [SelWidth-1:0] SEL_MIN  = 3'd3;
   localparam logic [SelWidth-1:0] SEL_MAX  = 3'd4;

   // Search phases
   localparam logic [PhaseWidth-1:0] PH_IDLE  = 2'd0;
   localparam logic [PhaseWidth-1:0] PH_CHECK = 2'd1;
   localparam logic [PhaseWidth-1:0] PH_SWEEP = 2'd2;

   // Register indexes
   localparam logic [CsrIdxWidth-1:0] REG_HFOV      = 3'd0;
   localparam logic [CsrIdxWidth-1:0] REG_VFOV      = 3'd1;
   localparam logic [CsrIdxWidth-1:0] REG_PAN_MIN   = 3'd2;
   localparam logic [CsrIdxWidth-1:0] REG_PAN_MAX   = 3'd3;
   localparam logic [CsrIdxWidth-1:0] REG_HOME_TILT = 3'd4;

   // Register reset values
   localparam logic [FovWidth-1:0]    HFOV_RESET      = 16'd11469;
   localparam logic [FovWidth-1:0]    VFOV_RESET      = 16'd8858;
   localparam logic [PanBndWidth-1:0] PAN_MIN_RESET   = 17'd0;
   localparam logic [PanBndWidth-1:0] PAN_MAX_RESET   = 17'd91904;
   localparam logic [TiltWidth-1:0]   HOME_TILT_RESET = 16'd0;

   typedef struct packed {
      logic [FovWidth-1:0]    hfov;
      logic [FovWidth-1:0]    vfov;
      logic [PanBndWidth-1:0] pan_min;
      logic [PanBndWidth-1:0] pan_max;
      logic [TiltWidth-1:0]   home_tilt;
   } cfg_type;

   typedef struct packed {
      logic [KindWidth-1:0] kind;
      logic [SelWidth-1:0]  sel;
   } ctl_type;

endpackage

// ===== rtl/core/pan_tilt_target_search_sequencer_top.sv =====
// Path: an accepted word goes from the input register to the result register,
//   and waits in the input register while the result register stays blocked.
// Throughput: one word per cycle while rsp_tready is high; the input register
//   and result register part the two sides, one multiplier per axis between them.
// Reset: synchronous, active high; registers return to their defaults,
//   the search ends and no offset is stored.
// ----------------------------------------------------------------------------
// Pan/tilt target search sequencer top level
// Stream in vision reports, stream out pan/tilt commands, plus a write port.
// ----------------------------------------------------------------------------
module pan_tilt_target_search_sequencer_top (
   input  logic                                  clock,
   input  logic                                  reset,
   // Report words
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [0] target_found, [1] move_wanted, [17:2] offset_x, [33:18] offset_y,
   // [34] motor_arrived, [39:35] zero
   input  logic [39:0]                           req_tdata,
   // Command words
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [17:0] pan_angle, [35:18] tilt_angle, [39:36] zero
   output logic [39:0]                           rsp_tdata,
   // [1:0] command_kind
   output logic [ptts_pkg::KindWidth-1:0]        rsp_tuser,
   // Register writes
   input  logic                                  csr_we,
   input  logic [ptts_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [ptts_pkg::CsrDatWidth-1:0]      csr_wdata
);

   ptts_pkg::cfg_type cfg_ff;
   ptts_pkg::ctl_type ctl;

   logic                                    in_valid_ff;
   logic                                    in_found_ff, in_want_ff, in_arrived_ff;
   logic signed [ptts_pkg::OffsetWidth-1:0] in_x_ff, in_y_ff;
   logic signed [ptts_pkg::OffsetWidth-1:0] last_x, last_y;
   logic signed [ptts_pkg::AngleWidth-1:0]  pan, tilt;
   logic                                    out_valid_ff;
   logic [ptts_pkg::KindWidth-1:0]          out_kind_ff;
   logic signed [ptts_pkg::AngleWidth-1:0]  out_pan_ff, out_tilt_ff;
   logic                                    fire;

   // Move a word to the result register when it is free or draining
   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hfov      <= ptts_pkg::HFOV_RESET;
         cfg_ff.vfov      <= ptts_pkg::VFOV_RESET;
         cfg_ff.pan_min   <= ptts_pkg::PAN_MIN_RESET;
         cfg_ff.pan_max   <= ptts_pkg::PAN_MAX_RESET;
         cfg_ff.home_tilt <= ptts_pkg::HOME_TILT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            ptts_pkg::REG_HFOV:
               cfg_ff.hfov <= csr_wdata[ptts_pkg::FovWidth-1:0];
            ptts_pkg::REG_VFOV:
               cfg_ff.vfov <= csr_wdata[ptts_pkg::FovWidth-1:0];
            ptts_pkg::REG_PAN_MIN:
               cfg_ff.pan_min <= csr_wdata[ptts_pkg::PanBndWidth-1:0];
            ptts_pkg::REG_PAN_MAX:
               cfg_ff.pan_max <= csr_wdata[ptts_pkg::PanBndWidth-1:0];
            ptts_pkg::REG_HOME_TILT:
               cfg_ff.home_tilt <= csr_wdata[ptts_pkg::TiltWidth-1:0];
            default: ;
         endcase
      end
   end

   // Hold the accepted report word
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_found_ff   <= req_tdata[0];
         in_want_ff    <= req_tdata[1];
         in_x_ff       <= $signed(req_tdata[17:2]);
         in_y_ff       <= $signed(req_tdata[33:18]);
         in_arrived_ff <= req_tdata[34];
      end
   end

   ptts_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .found    (in_found_ff),
      .want     (in_want_ff),
      .arrived  (in_arrived_ff),
      .offset_x (in_x_ff),
      .offset_y (in_y_ff),
      .ctl      (ctl),
      .last_x   (last_x),
      .last_y   (last_y)
   );

   ptts_math u_math (
      .ctl      (ctl),
      .cfg      (cfg_ff),
      .offset_x (in_x_ff),
      .offset_y (in_y_ff),
      .last_x   (last_x),
      .last_y   (last_y),
      .pan      (pan),
      .tilt     (tilt)
   );

   // Hold the command word until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_kind_ff <= ctl.kind;
         out_pan_ff  <= pan;
         out_tilt_ff <= tilt;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {4'b0, out_tilt_ff, out_pan_ff};

`include "pan_tilt_target_search_sequencer_top_assert.svh"

   // A command of no kind carries zero angles
   `PTTS_ASSERT_IMP(a_none_zero, clock, reset, rsp_tvalid && (rsp_tuser == ptts_pkg::KIND_NONE), rsp_tdata == 40'd0, "no-command word with nonzero angles")

   // A found target always yields a relative move
   `PTTS_ASSERT_NXT(a_found_rel, clock, reset, fire && in_found_ff, rsp_tvalid && (rsp_tuser == ptts_pkg::KIND_REL), "found target did not give a relative move")

   // A blocked report word stays in the input register unchanged
   `PTTS_ASSERT_NXT(a_in_hold, clock, reset, in_valid_ff && !fire, in_valid_ff && $stable(in_x_ff) && $stable(in_y_ff), "report word lost while blocked")

endmodule

// ===== rtl/core/ptts_seq.sv =====
// ----------------------------------------------------------------------------
// Pan/tilt search sequencer state
// Holds the search phase and last seen offset, picks the command per word.
// ----------------------------------------------------------------------------
module ptts_seq (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  fire,
   input  logic                                  found,
   input  logic                                  want,
   input  logic                                  arrived,
   input  logic signed [ptts_pkg::OffsetWidth-1:0] offset_x,
   input  logic signed [ptts_pkg::OffsetWidth-1:0] offset_y,
   output ptts_pkg::ctl_type                     ctl,
   output logic signed [ptts_pkg::OffsetWidth-1:0] last_x,
   output logic signed [ptts_pkg::OffsetWidth-1:0] last_y
);

   logic [ptts_pkg::PhaseWidth-1:0]         phase_ff, phase_in;
   logic                                    valid_ff, valid_in;
   logic                                    to_min_ff, to_min_in;
   logic signed [ptts_pkg::OffsetWidth-1:0] last_x_ff, last_x_in;
   logic signed [ptts_pkg::OffsetWidth-1:0] last_y_ff, last_y_in;

   // Decide the command and next state for the word in the input register
   always_comb begin
      phase_in  = phase_ff;
      valid_in  = valid_ff;
      to_min_in = to_min_ff;
      last_x_in = last_x_ff;
      last_y_in = last_y_ff;
      ctl.kind  = ptts_pkg::KIND_NONE;
      ctl.sel   = ptts_pkg::SEL_ZERO;
      if (found) begin
         last_x_in = offset_x;
         last_y_in = offset_y;
         valid_in  = 1'b1;
         phase_in  = ptts_pkg::PH_IDLE;
         ctl.kind  = ptts_pkg::KIND_REL;
         ctl.sel   = want ? ptts_pkg::SEL_REL : ptts_pkg::SEL_ZERO;
      end else begin
         unique case (phase_ff)
            ptts_pkg::PH_CHECK: begin
               if (arrived) begin
                  phase_in  = ptts_pkg::PH_SWEEP;
                  to_min_in = 1'b1;
                  ctl.kind  = ptts_pkg::KIND_ABS;
                  ctl.sel   = ptts_pkg::SEL_MIN;
               end
            end
            ptts_pkg::PH_SWEEP: begin
               if (arrived) begin
                  to_min_in = !to_min_ff;
                  ctl.kind  = ptts_pkg::KIND_ABS;
                  ctl.sel   = to_min_ff ? ptts_pkg::SEL_MAX : ptts_pkg::SEL_MIN;
               end
            end
            default: begin
               // Not searching (unused code behaves the same): start a search
               ctl.kind = ptts_pkg::KIND_ABS;
               if (valid_ff) begin
                  phase_in = ptts_pkg::PH_CHECK;
                  valid_in = 1'b0;
                  ctl.sel  = ptts_pkg::SEL_ABS;
               end else begin
                  phase_in  = ptts_pkg::PH_SWEEP;
                  to_min_in = 1'b1;
                  ctl.sel   = ptts_pkg::SEL_MIN;
               end
            end
         endcase
      end
   end

   // Advance state only when a word moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= ptts_pkg::PH_IDLE;
         valid_ff  <= 1'b0;
         to_min_ff <= 1'b0;
         last_x_ff <= '0;
         last_y_ff <= '0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         valid_ff  <= valid_in;
         to_min_ff <= to_min_in;
         last_x_ff <= last_x_in;
         last_y_ff <= last_y_in;
      end
   end

   assign last_x = last_x_ff;
   assign last_y = last_y_ff;

endmodule

// ===== rtl/core/ptts_math.sv =====
// ----------------------------------------------------------------------------
// Pan/tilt search sequencer angle datapath
// Scales offsets by the field of view and selects the commanded angles.
// ----------------------------------------------------------------------------
module ptts_math (
   input  ptts_pkg::ctl_type                      ctl,
   input  ptts_pkg::cfg_type                      cfg,
   input  logic signed [ptts_pkg::OffsetWidth-1:0] offset_x,
   input  logic signed [ptts_pkg::OffsetWidth-1:0] offset_y,
   input  logic signed [ptts_pkg::OffsetWidth-1:0] last_x,
   input  logic signed [ptts_pkg::OffsetWidth-1:0] last_y,
   output logic signed [ptts_pkg::AngleWidth-1:0]  pan,
   output logic signed [ptts_pkg::AngleWidth-1:0]  tilt
);

   localparam int OpW   = ptts_pkg::OffsetWidth + 1;
   localparam int ProdW = 2 * OpW;

   logic              rel;
   logic signed [OpW-1:0]   pan_op, tilt_op, hfov_op, vfov_op;
   logic signed [ProdW-1:0] pan_prod, tilt_prod;

   // Pick operands: new offset for relative moves, stored one otherwise
   assign rel     = (ctl.sel == ptts_pkg::SEL_REL);
   assign pan_op  = rel ? OpW'(offset_x) : OpW'(last_x);
   assign tilt_op = rel ? -OpW'(offset_y) : OpW'(last_y);
   assign hfov_op = $signed({1'b0, cfg.hfov});
   assign vfov_op = $signed({1'b0, cfg.vfov});

   // One multiplier per axis
   assign pan_prod  = pan_op * hfov_op;
   assign tilt_prod = tilt_op * vfov_op;

   // Scale: half field of view for relative moves, full for absolute
   always_comb begin
      unique case (ctl.sel)
         ptts_pkg::SEL_REL: begin
            pan  = pan_prod[ProdW-1 -: ptts_pkg::AngleWidth];
            tilt = tilt_prod[ProdW-1 -: ptts_pkg::AngleWidth];
         end
         ptts_pkg::SEL_ABS: begin
            pan  = pan_prod[ProdW-2 -: ptts_pkg::AngleWidth];
            tilt = tilt_prod[ProdW-2 -: ptts_pkg::AngleWidth];
         end
         ptts_pkg::SEL_MIN: begin
            pan  = $signed(ptts_pkg::AngleWidth'(cfg.pan_min));
            tilt = ptts_pkg::AngleWidth'($signed(cfg.home_tilt));
         end
         ptts_pkg::SEL_MAX: begin
            pan  = $signed(ptts_pkg::AngleWidth'(cfg.pan_max));
            tilt = ptts_pkg::AngleWidth'($signed(cfg.home_tilt));
         end
         default: begin
            pan  = '0;
            tilt = '0;
         end
      endcase
   end

endmodule
